// ===== rtl/core/pidmsc_pkg.sv =====
// shared constants for the pid motor speed controller
`timescale 1ns / 1ps

package pidmsc_pkg;

    // default width of the integral accumulator
    localparam int INTEGRAL_WIDTH_DEF = 48;

    // fixed-point position of the gains (unsigned Q8.16)
    localparam int GAIN_FRAC_BITS = 16;

    // field and register widths
    localparam int MS_W       = 8;
    localparam int TGT_W      = 16;
    localparam int PER_W      = 10;
    localparam int CPR_W      = 16;
    localparam int GAIN_W     = 24;
    localparam int CNT_W      = 16;
    localparam int DUTY_W     = 8;
    localparam int RPM_W      = 16;
    localparam int ERR_W      = 17;
    localparam int DE_W       = ERR_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // stream widths, padded to whole bytes
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 48;

    // serial units: multiplier digit count and divider sizes
    localparam int MUL_STEPS = GAIN_W;
    localparam int DIVD_W    = DE_W + GAIN_W;
    localparam int DIVS_W    = CNT_W;
    localparam int REM_W     = DIVS_W + 1;
    localparam int DIV_STEPS = DIVD_W;
    localparam int STEP_W    = 6;

    // pid sum accumulator and limits
    localparam int ACC_W          = 65;
    localparam int TERM_LIMIT_EXP = 62;
    localparam int SPEED_SCALE    = 1200;
    localparam int SCALED_W       = CNT_W + 11;
    localparam int DUTY_MAX       = 255;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_RPM = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_MS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CPR        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KP         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KI         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KD         = 3'd5;

    // reset values of the configuration registers
    localparam logic [TGT_W-1:0]  TARGET_RST = 16'd100;
    localparam logic [PER_W-1:0]  PERIOD_RST = 10'd50;
    localparam logic [CPR_W-1:0]  CPR_RST    = 16'd337;
    localparam logic [GAIN_W-1:0] KP_RST     = 24'd196608;
    localparam logic [GAIN_W-1:0] KI_RST     = 24'd66;
    localparam logic [GAIN_W-1:0] KD_RST     = 24'd65536;

    // input kind codes
    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

endpackage

// ===== rtl/core/pid_motor_speed_controller_core.sv =====
// An encoder edge or a tick that does not complete the sample period is taken while idle.
// A tick that completes the period starts an update, and no item is accepted until the result
// enters the output register. The update time is set by two passes of the 42-step bit-serial
// divider and four passes of the 24-step shift-add multiplier. aresetn is synchronous, active
// low; it restores the register defaults and clears counters, integral and last error.
`timescale 1ns / 1ps

module pid_motor_speed_controller_core
    import pidmsc_pkg::*;
#(
    parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input items
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] elapsed_ms
    input  logic                   s_tuser,   // [0] kind
    // result items
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [7:0] duty, [23:8] measured_rpm,
                                              // [40:24] speed_error, [47:41] zero
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int IW = INTEGRAL_WIDTH;
    localparam int SW = IW + 1;
    localparam int PW = IW + GAIN_W;
    localparam int CW = (PW > 64) ? PW : 64;
    localparam int RW = REM_W + DIVD_W;

    // sequencer states
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_DIV_RPM = 4'd1;
    localparam logic [3:0] ST_ERR     = 4'd2;
    localparam logic [3:0] ST_MUL_EDT = 4'd3;
    localparam logic [3:0] ST_INTEG   = 4'd4;
    localparam logic [3:0] ST_LOAD_I  = 4'd5;
    localparam logic [3:0] ST_MUL_I   = 4'd6;
    localparam logic [3:0] ST_ADD_I   = 4'd7;
    localparam logic [3:0] ST_MUL_P   = 4'd8;
    localparam logic [3:0] ST_ADD_P   = 4'd9;
    localparam logic [3:0] ST_MUL_D   = 4'd10;
    localparam logic [3:0] ST_LOAD_D  = 4'd11;
    localparam logic [3:0] ST_DIV_D   = 4'd12;
    localparam logic [3:0] ST_ADD_D   = 4'd13;
    localparam logic [3:0] ST_OUT     = 4'd14;

    // configuration registers
    logic [TGT_W-1:0]  target_reg, target_next;
    logic [PER_W-1:0]  period_reg, period_next;
    logic [CPR_W-1:0]  cpr_reg, cpr_next;
    logic [GAIN_W-1:0] kp_reg, kp_next;
    logic [GAIN_W-1:0] ki_reg, ki_next;
    logic [GAIN_W-1:0] kd_reg, kd_next;

    // controller state
    logic [CNT_W-1:0]  pulse_reg, pulse_next;
    logic [CNT_W-1:0]  elapsed_reg, elapsed_next;
    logic [IW-1:0]     integral_reg, integral_next;
    logic [ERR_W-1:0]  last_err_reg, last_err_next;
    logic [3:0]        state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              m_valid_reg, m_valid_next;

    // datapath registers
    logic [IW-1:0]     mul_a_reg, mul_a_next;
    logic [PW-1:0]     mul_p_reg, mul_p_next;
    logic [RW-1:0]     div_r_reg, div_r_next;
    logic [DIVS_W-1:0] div_d_reg, div_d_next;
    logic [ERR_W-1:0]  err_reg, err_next;
    logic [RPM_W-1:0]  rpm_reg, rpm_next;
    logic              de_neg_reg, de_neg_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [DUTY_W-1:0] duty_out_reg, duty_out_next;
    logic [RPM_W-1:0]  rpm_out_reg, rpm_out_next;
    logic [ERR_W-1:0]  err_out_reg, err_out_next;

    // shift-add multiplier step: multiplier bits sit in the low end of the product
    logic [IW:0]   mul_add;
    logic [PW-1:0] mul_step;
    assign mul_add  = {1'b0, mul_p_reg[PW-1:GAIN_W]} + (mul_p_reg[0] ? {1'b0, mul_a_reg} : '0);
    assign mul_step = {mul_add, mul_p_reg[GAIN_W-1:1]};

    // restoring divider step: one quotient bit per cycle
    logic [REM_W-1:0]  div_rem_sh, div_rem_new;
    logic [DIVD_W-1:0] div_quo;
    logic              div_ge;
    logic [RW-1:0]     div_step;
    assign div_quo     = div_r_reg[DIVD_W-1:0];
    assign div_rem_sh  = {div_r_reg[RW-2:DIVD_W], div_quo[DIVD_W-1]};
    assign div_ge      = div_rem_sh >= {1'b0, div_d_reg};
    assign div_rem_new = div_ge ? (div_rem_sh - {1'b0, div_d_reg}) : div_rem_sh;
    assign div_step    = {div_rem_new, div_quo[DIVD_W-2:0], div_ge};

    // tick bookkeeping
    logic [CNT_W:0]    el_sum;
    logic [CNT_W-1:0]  el_sat;
    logic [PER_W-1:0]  period_eff;
    logic [CPR_W-1:0]  cpr_eff;
    logic              trigger;
    logic [SCALED_W-1:0] pulse_scaled;
    assign el_sum       = {1'b0, elapsed_reg} + (CNT_W+1)'(s_tdata[MS_W-1:0]);
    assign el_sat       = el_sum[CNT_W] ? '1 : el_sum[CNT_W-1:0];
    assign period_eff   = (period_reg == '0) ? PER_W'(1) : period_reg;
    assign cpr_eff      = (cpr_reg == '0) ? CPR_W'(1) : cpr_reg;
    assign trigger      = el_sat >= CNT_W'(period_eff);
    assign pulse_scaled = SCALED_W'(pulse_reg) * SCALED_W'(SPEED_SCALE);

    // speed and error
    logic [RPM_W-1:0] rpm_sat;
    logic [ERR_W-1:0] err_calc, err_mag, err_reg_mag;
    assign rpm_sat     = (|div_quo[DIVD_W-1:RPM_W]) ? '1 : div_quo[RPM_W-1:0];
    assign err_calc    = {1'b0, target_reg} - {1'b0, rpm_sat};
    assign err_mag     = err_calc[ERR_W-1] ? (~err_calc + 1'b1) : err_calc;
    assign err_reg_mag = err_reg[ERR_W-1] ? (~err_reg + 1'b1) : err_reg;

    // saturating integral update with error * dt
    logic [SW-1:0] edt_mag, edt_term, int_sum;
    logic [IW-1:0] int_sat;
    assign edt_mag  = SW'(mul_p_reg[2*CNT_W-1:0]);
    assign edt_term = err_reg[ERR_W-1] ? (~edt_mag + 1'b1) : edt_mag;
    assign int_sum  = {integral_reg[IW-1], integral_reg} + edt_term;
    always_comb begin
        int_sat = int_sum[IW-1:0];
        if (int_sum[SW-1] != int_sum[SW-2]) begin
            int_sat = int_sum[SW-1] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
        end
    end

    // integral magnitude and the clamped integral term
    logic [IW-1:0]    int_mag;
    logic [CW-1:0]    iprod_ext;
    logic [ACC_W-1:0] i_mag, i_term;
    assign int_mag   = integral_reg[IW-1] ? (~integral_reg + 1'b1) : integral_reg;
    assign iprod_ext = CW'(mul_p_reg);
    assign i_mag     = (iprod_ext > (CW'(1) << TERM_LIMIT_EXP)) ?
                       (ACC_W'(1) << TERM_LIMIT_EXP) : ACC_W'(iprod_ext);
    assign i_term    = integral_reg[IW-1] ? (~i_mag + 1'b1) : i_mag;

    // proportional term and error difference
    logic [ACC_W-1:0] p_mag, p_term;
    logic [DE_W-1:0]  de_calc, de_mag;
    assign p_mag   = ACC_W'(mul_p_reg);
    assign p_term  = err_reg[ERR_W-1] ? (~p_mag + 1'b1) : p_mag;
    assign de_calc = {err_reg[ERR_W-1], err_reg} - {last_err_reg[ERR_W-1], last_err_reg};
    assign de_mag  = de_calc[DE_W-1] ? (~de_calc + 1'b1) : de_calc;

    // derivative term from the divider quotient
    logic [ACC_W-1:0] d_mag, d_term;
    assign d_mag  = ACC_W'(div_quo);
    assign d_term = de_neg_reg ? (~d_mag + 1'b1) : d_mag;

    // drive value from the pid sum
    logic [ACC_W-1:0]  acc_mag, acc_shr;
    logic [DUTY_W-1:0] duty_calc;
    assign acc_mag   = acc_reg[ACC_W-1] ? (~acc_reg + 1'b1) : acc_reg;
    assign acc_shr   = acc_mag >> GAIN_FRAC_BITS;
    assign duty_calc = (|acc_shr[ACC_W-1:DUTY_W]) ? DUTY_W'(DUTY_MAX) : acc_shr[DUTY_W-1:0];

    // handshakes
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = OUT_TDATA_W'({err_out_reg, rpm_out_reg, duty_out_reg});

    // configuration writes
    always_comb begin
        target_next = target_reg;
        period_next = period_reg;
        cpr_next    = cpr_reg;
        kp_next     = kp_reg;
        ki_next     = ki_reg;
        kd_next     = kd_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_TARGET_RPM: target_next = cfg_data[TGT_W-1:0];
                REG_SAMPLE_MS:  period_next = cfg_data[PER_W-1:0];
                REG_CPR:        cpr_next    = cfg_data[CPR_W-1:0];
                REG_KP:         kp_next     = cfg_data[GAIN_W-1:0];
                REG_KI:         ki_next     = cfg_data[GAIN_W-1:0];
                REG_KD:         kd_next     = cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // update sequencer
    always_comb begin
        pulse_next    = pulse_reg;
        elapsed_next  = elapsed_reg;
        integral_next = integral_reg;
        last_err_next = last_err_reg;
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_valid_next  = m_valid_reg;
        mul_a_next    = mul_a_reg;
        mul_p_next    = mul_p_reg;
        div_r_next    = div_r_reg;
        div_d_next    = div_d_reg;
        err_next      = err_reg;
        rpm_next      = rpm_reg;
        de_neg_next   = de_neg_reg;
        acc_next      = acc_reg;
        duty_out_next = duty_out_reg;
        rpm_out_next  = rpm_out_reg;
        err_out_next  = err_out_reg;

        // result taken downstream
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    if (s_tuser == KIND_EDGE) begin
                        if (pulse_reg != '1) begin
                            pulse_next = pulse_reg + 1'b1;
                        end
                    end else begin
                        elapsed_next = el_sat;
                        if (trigger) begin
                            div_r_next = RW'(pulse_scaled);
                            div_d_next = cpr_eff;
                            cnt_next   = '0;
                            state_next = ST_DIV_RPM;
                        end
                    end
                end
            end
            ST_DIV_RPM: begin
                div_r_next = div_step;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(DIV_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_ERR;
                end
            end
            ST_ERR: begin
                rpm_next   = rpm_sat;
                err_next   = err_calc;
                mul_a_next = IW'(err_mag);
                mul_p_next = PW'(elapsed_reg);
                state_next = ST_MUL_EDT;
            end
            ST_MUL_EDT, ST_MUL_I, ST_MUL_P, ST_MUL_D: begin
                mul_p_next = mul_step;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(MUL_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = state_reg + 1'b1;
                end
            end
            ST_INTEG: begin
                integral_next = int_sat;
                state_next    = ST_LOAD_I;
            end
            ST_LOAD_I: begin
                mul_a_next = int_mag;
                mul_p_next = PW'(ki_reg);
                state_next = ST_MUL_I;
            end
            ST_ADD_I: begin
                acc_next   = i_term;
                mul_a_next = IW'(err_reg_mag);
                mul_p_next = PW'(kp_reg);
                state_next = ST_MUL_P;
            end
            ST_ADD_P: begin
                acc_next    = acc_reg + p_term;
                de_neg_next = de_calc[DE_W-1];
                mul_a_next  = IW'(de_mag);
                mul_p_next  = PW'(kd_reg);
                state_next  = ST_MUL_D;
            end
            ST_LOAD_D: begin
                div_r_next = RW'(mul_p_reg[DIVD_W-1:0]);
                div_d_next = elapsed_reg;
                cnt_next   = '0;
                state_next = ST_DIV_D;
            end
            ST_DIV_D: begin
                div_r_next = div_step;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(DIV_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_ADD_D;
                end
            end
            ST_ADD_D: begin
                acc_next      = acc_reg + d_term;
                last_err_next = err_reg;
                pulse_next    = '0;
                elapsed_next  = '0;
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                // wait for a free output register
                if (!m_valid_reg || m_tready) begin
                    duty_out_next = duty_calc;
                    rpm_out_next  = rpm_reg;
                    err_out_next  = err_reg;
                    m_valid_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg   <= TARGET_RST;
            period_reg   <= PERIOD_RST;
            cpr_reg      <= CPR_RST;
            kp_reg       <= KP_RST;
            ki_reg       <= KI_RST;
            kd_reg       <= KD_RST;
            pulse_reg    <= '0;
            elapsed_reg  <= '0;
            integral_reg <= '0;
            last_err_reg <= '0;
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            target_reg   <= target_next;
            period_reg   <= period_next;
            cpr_reg      <= cpr_next;
            kp_reg       <= kp_next;
            ki_reg       <= ki_next;
            kd_reg       <= kd_next;
            pulse_reg    <= pulse_next;
            elapsed_reg  <= elapsed_next;
            integral_reg <= integral_next;
            last_err_reg <= last_err_next;
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        mul_a_reg    <= mul_a_next;
        mul_p_reg    <= mul_p_next;
        div_r_reg    <= div_r_next;
        div_d_reg    <= div_d_next;
        err_reg      <= err_next;
        rpm_reg      <= rpm_next;
        de_neg_reg   <= de_neg_next;
        acc_reg      <= acc_next;
        duty_out_reg <= duty_out_next;
        rpm_out_reg  <= rpm_out_next;
        err_out_reg  <= err_out_next;
    end

`ifndef NO_ASSERTIONS
    // step counter never runs past the longest serial pass
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg < STEP_W'(DIV_STEPS))
        else $error("serial step counter out of range");

    // a result only appears from the output stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result raised outside the output stage");

    // an update clears the pulse and time counters
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ADD_D |=> pulse_reg == '0 && elapsed_reg == '0)
        else $error("counters not cleared by update");

    // pulse count holds while an update is running, until the derivative add clears it
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE && state_reg != ST_ADD_D) |=> $stable(pulse_reg))
        else $error("pulse count changed during update");
`endif

endmodule

// ===== dv/tb_pid_motor_speed_controller_core.sv =====
// self-checking testbench for the pid motor speed controller core
`timescale 1ns / 1ps

module tb_pid_motor_speed_controller_core;
    import pidmsc_pkg::*;

    localparam int INTEG_W       = INTEGRAL_WIDTH_DEF;
    localparam int SETTLE_CYCLES = 200;      // one full update plus margin
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 550;
    localparam int IDLE_PCT      = 38;
    localparam int DIR_N         = 30;
    localparam logic [63:0] TERM_CAP = 64'd1 << TERM_LIMIT_EXP;

    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [DUTY_W-1:0]        duty;
        logic [RPM_W-1:0]         rpm;
        logic signed [ERR_W-1:0]  err;
    } speed_report_t;

    typedef struct {
        bit            pinned;
        speed_report_t rep;
    } pin_entry_t;

    typedef enum logic {ROW_ITEM, ROW_WRITE} row_op_e;

    // items use kind and value (elapsed ms); writes use index and value
    typedef struct packed {
        row_op_e                op;
        logic                   kind;
        logic [CFG_IDX_W-1:0]   index;
        logic [CFG_DATA_W-1:0]  value;
        logic                   pinned;
        speed_report_t          rep;
    } dir_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // predictor copy of registers and state
    logic [TGT_W-1:0]  cfg_target;
    logic [PER_W-1:0]  cfg_period;
    logic [CPR_W-1:0]  cfg_cpr;
    logic [GAIN_W-1:0] cfg_kp;
    logic [GAIN_W-1:0] cfg_ki;
    logic [GAIN_W-1:0] cfg_kd;
    logic [CNT_W-1:0]  pulse_tally;
    logic [CNT_W-1:0]  ms_tally;
    longint            integ_acc;
    longint            prev_error;

    speed_report_t report_q[$];
    pin_entry_t    pin_q[$];
    int            mismatches;
    int            items_sent;
    int unsigned   cycle_count = 0;
    bit            no_gaps;

    dir_row_t dir_rows [DIR_N] = '{
        '{ROW_ITEM,  KIND_TICK, REG_TARGET_RPM, 24'd0,    1'b0, '0},
        '{ROW_ITEM,  KIND_TICK, REG_TARGET_RPM, 24'd50,   1'b1, '{8'd255, 16'd0, 17'sd100}},
        '{ROW_ITEM,  KIND_EDGE, REG_TARGET_RPM, 24'd255,  1'b0, '0},
        '{ROW_ITEM,  KIND_EDGE, REG_TARGET_RPM, 24'd0,    1'b0, '0},
        '{ROW_ITEM,  KIND_EDGE, REG_TARGET_RPM, 24'd170,  1'b0, '0},
        '{ROW_ITEM,  KIND_TICK, REG_TARGET_RPM, 24'd255,  1'b0, '0},
        '{ROW_ITEM,  KIND_TICK, REG_TARGET_RPM, 24'd49,   1'b0, '0},
        '{ROW_ITEM,  KIND_EDGE, REG_TARGET_RPM, 24'd85,   1'b0, '0},
        '{ROW_ITEM,  KIND_TICK, REG_TARGET_RPM, 24'd1,    1'b0, '0},
        '{ROW_WRITE, KIND_EDGE, REG_SAMPLE_MS,  24'd1000, 1'b0, '0},
        '{ROW_WRITE, KIND_EDGE, REG_TARGET_RPM, 24'd65535, 1'b0, '0},
        '{ROW_WRITE, KIND_EDGE, REG_CPR,        24'd65535, 1'b0, '0},
        '{ROW_WRITE, KIND_EDGE, REG_KP,         24'hFFFFFF, 1'b0, '0},
        '{ROW_WRITE, KIND_EDGE, REG_KI,         24'hFFFFFF, 1'b0, '0},
        '{ROW_WRITE, KIND_EDGE, REG_KD,         24'hFFFFFF, 1'b0, '0},
        '{ROW_ITEM,  KIND_TICK, REG_TARGET_RPM, 24'd255,  1'b0, '0},
        '{ROW_ITEM,  KIND_TICK, REG_TARGET_RPM, 24'd255,  1'b0, '0},
        '{ROW_ITEM,  KIND_TICK, REG_TARGET_RPM, 24'd255,  1'b0, '0},
        '{ROW_WRITE, KIND_EDGE, REG_SAMPLE_MS,  24'd0,    1'b0, '0},
        '{ROW_WRITE, KIND_EDGE, REG_CPR,        24'd0,    1'b0, '0},
        '{ROW_ITEM,  KIND_EDGE, REG_TARGET_RPM, 24'd255,  1'b0, '0},
        '{ROW_ITEM,  KIND_TICK, REG_TARGET_RPM, 24'd0,    1'b1,
          '{8'd255, 16'd1200, 17'sd64335}},
        '{ROW_WRITE, KIND_EDGE, REG_TARGET_RPM, 24'd0,    1'b0, '0},
        '{ROW_WRITE, KIND_EDGE, REG_KP,         24'd0,    1'b0, '0},
        '{ROW_WRITE, KIND_EDGE, REG_KI,         24'd0,    1'b0, '0},
        '{ROW_WRITE, KIND_EDGE, REG_KD,         24'd0,    1'b0, '0},
        '{ROW_ITEM,  KIND_TICK, REG_TARGET_RPM, 24'd7,    1'b1, '{8'd0, 16'd0, 17'sd0}},
        '{ROW_WRITE, KIND_EDGE, REG_SPARE_6,    24'hFFFFFF, 1'b0, '0},
        '{ROW_WRITE, KIND_EDGE, REG_SPARE_7,    24'hFFFFFF, 1'b0, '0},
        '{ROW_ITEM,  KIND_TICK, REG_TARGET_RPM, 24'd1,    1'b1, '{8'd0, 16'd0, 17'sd0}}
    };

    pid_motor_speed_controller_core #(
        .INTEGRAL_WIDTH(INTEG_W)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // cycle counter for the run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // random back-pressure on the report side, off while no_gaps is set
    always @(negedge aclk) begin
        m_tready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // one control update of the predictor; returns 1 when a report comes out
    function automatic bit run_pid_step(input logic kind, input logic [MS_W-1:0] ms,
                                        output speed_report_t rep);
        logic [63:0] sum_ms, period, cdiv, speed, dt, imag, dmag, smag;
        longint      err, inc, hi, lo, de, p_term, i_term, d_term, pid_sum;
        rep = '0;
        if (kind == KIND_EDGE) begin
            if (pulse_tally != '1) pulse_tally++;
            return 1'b0;
        end

        // accumulate time, saturating
        sum_ms = 64'(ms_tally) + 64'(ms);
        ms_tally = (sum_ms > 64'hFFFF) ? '1 : CNT_W'(sum_ms);
        period = (cfg_period == 0) ? 64'd1 : 64'(cfg_period);
        if (64'(ms_tally) < period) return 1'b0;

        // speed and error
        cdiv = (cfg_cpr == 0) ? 64'd1 : 64'(cfg_cpr);
        speed = (64'(pulse_tally) * 64'(SPEED_SCALE)) / cdiv;
        if (speed > 64'hFFFF) speed = 64'hFFFF;
        err = longint'(cfg_target) - longint'(speed);
        dt = 64'(ms_tally);

        // saturating integral
        hi = longint'((64'd1 << (INTEG_W - 1)) - 64'd1);
        lo = -hi - 1;
        inc = err * longint'(dt);
        if (inc > 0 && integ_acc > hi - inc) integ_acc = hi;
        else if (inc < 0 && integ_acc < lo - inc) integ_acc = lo;
        else integ_acc = integ_acc + inc;

        // pid terms in Q.16
        p_term = longint'(cfg_kp) * err;
        imag = (integ_acc < 0) ? -integ_acc : integ_acc;
        if (cfg_ki != 0 && imag > TERM_CAP / 64'(cfg_ki)) imag = TERM_CAP;
        else imag = imag * 64'(cfg_ki);
        i_term = (integ_acc < 0) ? -longint'(imag) : longint'(imag);
        de = err - prev_error;
        dmag = (de < 0) ? -de : de;
        dmag = (dmag * 64'(cfg_kd)) / dt;
        d_term = (de < 0) ? -longint'(dmag) : longint'(dmag);

        // drive magnitude, clamped
        pid_sum = p_term + i_term + d_term;
        smag = (pid_sum < 0) ? -pid_sum : pid_sum;
        smag = smag >> GAIN_FRAC_BITS;
        rep.duty = (smag > 64'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX) : DUTY_W'(smag);
        rep.rpm  = RPM_W'(speed);
        rep.err  = ERR_W'(err);

        prev_error  = err;
        pulse_tally = '0;
        ms_tally    = '0;
        return 1'b1;
    endfunction

    // report checking, register tracking and prediction on accepted items
    always @(posedge aclk) begin : score
        speed_report_t got;
        speed_report_t want;
        pin_entry_t    pin;
        if (!aresetn) begin
            // predictor follows the block into reset
            cfg_target  = TARGET_RST;
            cfg_period  = PERIOD_RST;
            cfg_cpr     = CPR_RST;
            cfg_kp      = KP_RST;
            cfg_ki      = KI_RST;
            cfg_kd      = KD_RST;
            pulse_tally = '0;
            ms_tally    = '0;
            integ_acc   = 0;
            prev_error  = 0;
            mismatches  = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.duty = m_tdata[DUTY_W-1:0];
                got.rpm  = m_tdata[DUTY_W+RPM_W-1:DUTY_W];
                got.err  = m_tdata[DUTY_W+RPM_W+ERR_W-1:DUTY_W+RPM_W];
                if (report_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: report with none expected, duty %0d rpm %0d error %0d",
                             $time, got.duty, got.rpm, got.err);
                end else begin
                    want = report_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        $display("%0t: expected duty %0d rpm %0d error %0d,",
                                 $time, want.duty, want.rpm, want.err,
                                 " got duty %0d rpm %0d error %0d",
                                 got.duty, got.rpm, got.err);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_TARGET_RPM: cfg_target = cfg_data[TGT_W-1:0];
                    REG_SAMPLE_MS:  cfg_period = cfg_data[PER_W-1:0];
                    REG_CPR:        cfg_cpr    = cfg_data[CPR_W-1:0];
                    REG_KP:         cfg_kp     = cfg_data[GAIN_W-1:0];
                    REG_KI:         cfg_ki     = cfg_data[GAIN_W-1:0];
                    REG_KD:         cfg_kd     = cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                pin = pin_q.pop_front();
                if (run_pid_step(s_tuser, s_tdata[MS_W-1:0], want)) begin
                    if (pin.pinned) want = pin.rep;
                    report_q.push_back(want);
                end
            end
        end
    end

    // offer one item, with random gaps ahead of it
    task automatic send_item(input logic kind, input logic [MS_W-1:0] ms, input bit pinned,
                             input speed_report_t rep);
        pin_entry_t pin;
        pin.pinned = pinned;
        pin.rep    = rep;
        pin_q.push_back(pin);
        while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= ms;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // single register write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // wait for all pending reports, then let the block go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (report_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // register value for a random phase, extremes included
    function automatic logic [CFG_DATA_W-1:0] pick_setting(input logic [CFG_IDX_W-1:0] idx);
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        if (roll == 2) return CFG_DATA_W'($urandom);
        case (idx)
            REG_TARGET_RPM: return CFG_DATA_W'($urandom_range(0, 3000));
            REG_SAMPLE_MS:  return CFG_DATA_W'($urandom_range(1, 60));
            REG_CPR:        return CFG_DATA_W'($urandom_range(1, 400));
            default:        return CFG_DATA_W'($urandom_range(0, 24'h3FFFF));
        endcase
    endfunction

    // timeout
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_pid_motor_speed_controller_core failed");
        $finish;
    end

    // main sequence
    initial begin
        int          phase;
        bit          idle_now;
        logic        kind;
        logic [MS_W-1:0] ms;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        aresetn      = 1'b0;
        no_gaps      = 1'b0;
        items_sent   = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed table: reset defaults, extremes, late edge, zero period and cpr
        idle_now = 1'b1;
        for (int n = 0; n < DIR_N; n++) begin
            if (dir_rows[n].op == ROW_WRITE) begin
                if (!idle_now) settle();
                idle_now = 1'b1;
                write_reg(dir_rows[n].index, dir_rows[n].value);
            end else begin
                send_item(dir_rows[n].kind, dir_rows[n].value[MS_W-1:0],
                          dir_rows[n].pinned, dir_rows[n].rep);
                idle_now = 1'b0;
            end
        end

        // random phases, each with fresh register settings
        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            settle();
            for (logic [CFG_IDX_W-1:0] r = REG_TARGET_RPM; r <= REG_KD; r++) begin
                write_reg(r, pick_setting(r));
            end
            if ($urandom_range(0, 4) == 0) begin
                write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7,
                          CFG_DATA_W'($urandom));
            end
            no_gaps = (phase == 1);
            repeat ($urandom_range(40, 90)) begin
                kind = ($urandom_range(0, 9) < 3) ? KIND_TICK : KIND_EDGE;
                case ($urandom_range(0, 9))
                    0:       ms = '0;
                    1:       ms = '1;
                    default: ms = MS_W'($urandom_range(0, 255));
                endcase
                send_item(kind, ms, 1'b0, '0);
                items_sent++;
            end
            phase++;
        end
        no_gaps = 1'b0;
        settle();

        if (mismatches == 0) begin
            $display("tb_pid_motor_speed_controller_core passed");
        end else begin
            $display("tb_pid_motor_speed_controller_core failed");
        end
        $finish;
    end

endmodule
